>>> hw/rtl/etit_pkg.sv
package etit_pkg;

   // number format: signed fixed point, Q4.28
   localparam int WORD_BITS     = 32;
   localparam int FRACTION_BITS = 28;
   localparam int COUNT_BITS    = 16;

   typedef logic signed [WORD_BITS-1:0] word_type;
   typedef logic [COUNT_BITS-1:0]       count_type;

   localparam count_type MAX_ITER_RESET = COUNT_BITS'(64);

   typedef struct packed {
      word_type start_re;
      word_type start_im;
      word_type const_re;
      word_type const_im;
   } req_type;

   typedef struct packed {
      count_type iteration_count;
      logic      escaped;
      word_type  final_re;
      word_type  final_im;
   } rsp_type;

   // operand pair for the shared multiplier
   typedef enum logic [1:0] {
      MUL_RR,
      MUL_II,
      MUL_RI
   } mul_sel_type;

   typedef struct packed {
      logic        load;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        sat_en;
      mul_sel_type sat_sel;
      logic        diff_en;
      logic        update_en;
   } cmd_type;

   typedef struct packed {
      logic limit_hit;
      logic escape_hit;
   } status_type;

endpackage

>>> hw/rtl/etit_ctrl.sv
module etit_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   output logic                rsp_valid,
   output etit_pkg::cmd_type    cmd,
   input  etit_pkg::status_type status
);
   import etit_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_MUL_RR,
      S_MUL_II,
      S_MUL_RI,
      S_SAT_RI,
      S_UPDATE
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (start) state_ff <= S_CHECK;
            end
            S_CHECK: begin
               if (status.limit_hit) begin
                  state_ff     <= S_IDLE;
                  rsp_valid_ff <= 1'b1;
               end else begin
                  state_ff <= S_MUL_RR;
               end
            end
            S_MUL_RR: state_ff <= S_MUL_II;
            S_MUL_II: state_ff <= S_MUL_RI;
            S_MUL_RI: state_ff <= S_SAT_RI;
            S_SAT_RI: begin
               if (status.escape_hit) begin
                  state_ff     <= S_IDLE;
                  rsp_valid_ff <= 1'b1;
               end else begin
                  state_ff <= S_UPDATE;
               end
            end
            S_UPDATE: state_ff <= S_CHECK;
            default:  state_ff <= S_IDLE;
         endcase
      end
   end

   always_comb begin
      cmd           = '0;
      cmd.mul_sel   = MUL_RR;
      cmd.sat_sel   = MUL_RR;
      case (state_ff)
         S_IDLE:   cmd.load = start;
         S_MUL_RR: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_RR;
         end
         S_MUL_II: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_II;
            cmd.sat_en  = 1'b1;
            cmd.sat_sel = MUL_RR;
         end
         S_MUL_RI: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_RI;
            cmd.sat_en  = 1'b1;
            cmd.sat_sel = MUL_II;
         end
         S_SAT_RI: begin
            cmd.sat_en  = 1'b1;
            cmd.sat_sel = MUL_RI;
            cmd.diff_en = 1'b1;
         end
         S_UPDATE: cmd.update_en = 1'b1;
         default:  cmd.load = 1'b0;
      endcase
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

>>> hw/rtl/etit_dp.sv
module etit_dp (
   input  logic                  clock,
   input  etit_pkg::req_type     req_data,
   input  etit_pkg::count_type   max_iterations,
   input  etit_pkg::cmd_type     cmd,
   output etit_pkg::status_type  status,
   output etit_pkg::rsp_type     rsp_data
);
   import etit_pkg::*;

   localparam int PW = 2 * WORD_BITS;
   localparam word_type WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
   localparam word_type WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
   localparam logic [WORD_BITS:0] ESCAPE_BOUND =
      (WORD_BITS+1)'(1) << (FRACTION_BITS + 2);

   // clamp a one-bit-wider signed value to the word range
   function automatic word_type sat_word(input logic signed [WORD_BITS:0] v);
      if (v[WORD_BITS] != v[WORD_BITS-1]) return v[WORD_BITS] ? WORD_MIN : WORD_MAX;
      return v[WORD_BITS-1:0];
   endfunction

   // floor shift of the exact product, then clamp
   function automatic word_type sat_prod(input logic signed [PW-1:0] p);
      logic signed [PW-1:0]     s;
      logic [PW-WORD_BITS:0]    hi;
      s  = p >>> FRACTION_BITS;
      hi = s[PW-1:WORD_BITS-1];
      if ((&hi) || (~|hi)) return s[WORD_BITS-1:0];
      return s[PW-1] ? WORD_MIN : WORD_MAX;
   endfunction

   word_type  re_ff, im_ff, cre_ff, cim_ff;
   word_type  r2_ff, i2_ff, cross_ff, diff_ff;
   count_type count_ff;
   logic signed [PW-1:0] prod_ff;

   word_type  mul_a, mul_b;
   logic signed [PW-1:0] prod_in;
   word_type  sat_in, diff_in, re_in, im_in, dbl;
   logic [WORD_BITS:0] mag_sum;

   always_comb begin
      case (cmd.mul_sel)
         MUL_RR: begin mul_a = re_ff; mul_b = re_ff; end
         MUL_II: begin mul_a = im_ff; mul_b = im_ff; end
         MUL_RI: begin mul_a = re_ff; mul_b = im_ff; end
         default: begin mul_a = re_ff; mul_b = re_ff; end
      endcase
   end

   assign prod_in = PW'(mul_a) * PW'(mul_b);
   assign sat_in  = sat_prod(prod_ff);
   assign diff_in = sat_word({r2_ff[WORD_BITS-1], r2_ff} - {i2_ff[WORD_BITS-1], i2_ff});
   assign dbl     = sat_word({cross_ff, 1'b0});
   assign re_in   = sat_word({diff_ff[WORD_BITS-1], diff_ff} + {cre_ff[WORD_BITS-1], cre_ff});
   assign im_in   = sat_word({dbl[WORD_BITS-1], dbl} + {cim_ff[WORD_BITS-1], cim_ff});

   // squares are never negative, so the sum alone decides escape
   assign mag_sum = {1'b0, r2_ff} + {1'b0, i2_ff};

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         re_ff    <= req_data.start_re;
         im_ff    <= req_data.start_im;
         cre_ff   <= req_data.const_re;
         cim_ff   <= req_data.const_im;
         count_ff <= '0;
      end else if (cmd.update_en) begin
         re_ff    <= re_in;
         im_ff    <= im_in;
         count_ff <= count_ff + COUNT_BITS'(1);
      end
      if (cmd.mul_en) prod_ff <= prod_in;
      if (cmd.sat_en) begin
         case (cmd.sat_sel)
            MUL_RR:  r2_ff    <= sat_in;
            MUL_II:  i2_ff    <= sat_in;
            MUL_RI:  cross_ff <= sat_in;
            default: r2_ff    <= sat_in;
         endcase
      end
      if (cmd.diff_en) diff_ff <= diff_in;
   end

   assign status.limit_hit  = (count_ff >= max_iterations);
   assign status.escape_hit = (mag_sum >= ESCAPE_BOUND);

   assign rsp_data.iteration_count = count_ff;
   assign rsp_data.escaped         = (count_ff < max_iterations);
   assign rsp_data.final_re        = re_ff;
   assign rsp_data.final_im        = im_ff;

endmodule

>>> hw/rtl/escape_time_iteration.sv
// sequence: each iteration checks the limit, forms three products, tests for escape
// and updates z, until the limit stops the point or it escapes; one shared 32x32
// multiplier forms re^2, im^2 and re*im in turn
// transactions: one at a time, no new start is taken while busy;
// the next start is taken in the strobe cycle
// reset: synchronous, active high; clears the controller and sets the limit to 64
module escape_time_iteration (
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 start,
   output logic                 busy,
   input  etit_pkg::req_type    req_data,
   // result channel, one-cycle strobe, receiver cannot stall
   output logic                 rsp_valid,
   output etit_pkg::rsp_type    rsp_data,
   // iteration limit register
   input  logic                 csr_we,
   input  etit_pkg::count_type  csr_wdata
);
   import etit_pkg::*;

   count_type  max_iterations_ff;
   cmd_type    cmd;
   status_type status;

   // limit register, only to be written while no transaction is in flight; the block does not enforce this
   always_ff @(posedge clock) begin
      if (reset) begin
         max_iterations_ff <= MAX_ITER_RESET;
      end else if (csr_we) begin
         max_iterations_ff <= csr_wdata;
      end
   end

   // sequencer: limit check, three products, escape test, z update
   etit_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .status    (status)
   );

   // z registers, shared multiplier, saturation and counter
   etit_dp u_dp (
      .clock          (clock),
      .req_data       (req_data),
      .max_iterations (max_iterations_ff),
      .cmd            (cmd),
      .status         (status),
      .rsp_data       (rsp_data)
   );

endmodule

>>> hw/rtl/etit_checker.sv
module etit_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_valid,
   input etit_pkg::rsp_type rsp_data
);
   import etit_pkg::*;

   // an accepted transaction keeps the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not raise busy");

   // a result strobe is a single cycle
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   // the strobe comes only once the block is idle
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

   // finishing a transaction always yields its result
   a_fall_result: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("busy dropped without a result");

   // a result transaction carries fully known data
   a_rsp_known: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !$isunknown(rsp_data))
      else $error("result data unknown during strobe");

endmodule

bind escape_time_iteration etit_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

>>> test/tb_escape_time_iteration.sv
module tb_escape_time_iteration;
   timeunit 1ns;
   timeprecision 1ps;

   import etit_pkg::*;

   // q4.28 helpers and bounds of the signed word
   localparam longint WORD_MAX    = (longint'(1) <<< (WORD_BITS - 1)) - 1;
   localparam longint WORD_MIN    = -WORD_MAX - 1;
   localparam longint RADIUS_SQ   = longint'(1) <<< (FRACTION_BITS + 2);
   localparam word_type W_MAX     = 32'sh7FFF_FFFF;
   localparam word_type W_MIN     = 32'sh8000_0000;
   localparam word_type Q_TWO     = 32'sh2000_0000;
   localparam word_type Q_ONE     = 32'sh1000_0000;
   localparam int       CYCLE_LIMIT = 12_000_000;
   localparam int       RANDOM_ITEMS = 750;

   logic      clock = 1'b0;
   logic      reset = 1'b1;
   logic      start = 1'b0;
   logic      busy;
   req_type   req_data = '0;
   logic      rsp_valid;
   rsp_type   rsp_data;
   logic      csr_we = 1'b0;
   count_type csr_wdata = '0;

   // points waiting to be launched, and the results predicted for launched ones
   req_type   point_queue[$];
   rsp_type   expected_escape[$];
   count_type iter_limit = MAX_ITER_RESET;
   int        idle_pct = 25;
   int        mismatches = 0;
   int        cycle_count = 0;
   rsp_type   got_want;

   escape_time_iteration u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always #6 clock = ~clock;

   // clamp to the signed word range
   function automatic longint fx_clamp(longint v);
      if (v > WORD_MAX) return WORD_MAX;
      if (v < WORD_MIN) return WORD_MIN;
      return v;
   endfunction

   // exact product, floor shift by the fraction, then saturate
   function automatic longint fx_mul(longint a, longint b);
      return fx_clamp((a * b) >>> FRACTION_BITS);
   endfunction

   // iterate z <- z*z + c until escape or the limit, as the block should
   function automatic rsp_type predict_escape(req_type item, count_type limit);
      longint      zr;
      longint      zi;
      longint      cr;
      longint      ci;
      longint      r2;
      longint      i2;
      longint      ri;
      int unsigned steps;
      rsp_type     res;
      zr = longint'($signed(item.start_re));
      zi = longint'($signed(item.start_im));
      cr = longint'($signed(item.const_re));
      ci = longint'($signed(item.const_im));
      steps = 0;
      forever begin
         r2 = fx_mul(zr, zr);
         i2 = fx_mul(zi, zi);
         // escape test works on the saturated squares and their sum
         if (steps >= limit || r2 >= RADIUS_SQ || i2 >= RADIUS_SQ || r2 + i2 >= RADIUS_SQ)
            break;
         ri = fx_mul(zr, zi);
         zr = fx_clamp(fx_clamp(r2 - i2) + cr);
         zi = fx_clamp(fx_clamp(ri + ri) + ci);
         steps++;
      end
      res.iteration_count = count_type'(steps);
      res.escaped         = (steps < limit);
      res.final_re        = word_type'(zr);
      res.final_im        = word_type'(zi);
      return res;
   endfunction

   // driver: launch queued points, hold a command while the block is busy
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         // transaction taken at this edge: predict it with the current limit
         if (start && !busy)
            expected_escape.push_back(predict_escape(req_data, iter_limit));
         if (start && busy) begin
            // keep the command and its data in place
         end else if (point_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
            req_data <= point_queue.pop_front();
            start    <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: every strobe is one result transaction, compared with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_escape.size() == 0) begin
            $error("result transaction with no prediction pending");
            mismatches++;
         end else begin
            got_want = expected_escape.pop_front();
            if (rsp_data.iteration_count !== got_want.iteration_count) begin
               $error("iteration_count: expected %0d, actual %0d",
                      got_want.iteration_count, rsp_data.iteration_count);
               mismatches++;
            end
            if (rsp_data.escaped !== got_want.escaped) begin
               $error("escaped: expected %0b, actual %0b", got_want.escaped, rsp_data.escaped);
               mismatches++;
            end
            if (rsp_data.final_re !== got_want.final_re) begin
               $error("final_re: expected %0d, actual %0d", got_want.final_re, rsp_data.final_re);
               mismatches++;
            end
            if (rsp_data.final_im !== got_want.final_im) begin
               $error("final_im: expected %0d, actual %0d", got_want.final_im, rsp_data.final_im);
               mismatches++;
            end
         end
      end
   end

   // watchdog on the whole run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("escape_time_iteration regression: fail");
         $finish;
      end
   end

   task automatic add_point(word_type sr, word_type si, word_type cr, word_type ci);
      req_type item;
      item.start_re = sr;
      item.start_im = si;
      item.const_re = cr;
      item.const_im = ci;
      point_queue.push_back(item);
   endtask

   // block is idle once nothing is queued, launched or outstanding
   task automatic wait_idle();
      while (point_queue.size() != 0 || start || expected_escape.size() != 0)
         @(posedge clock);
      @(posedge clock);
   endtask

   // limit register write, only between phases
   task automatic set_limit(count_type value);
      wait_idle();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      iter_limit = value;
   endtask

   initial begin
      int        issued;
      int        phase;
      int        batch;
      int        sel;
      int        kind;
      count_type lim;
      word_type  jc_re;
      word_type  jc_im;
      word_type  sr;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed, at the reset limit of 64
      add_point(0, 0, 0, 0);                          // origin stays put, runs to the limit
      add_point(W_MAX, W_MAX, W_MAX, W_MAX);          // escaped at start, top corner
      add_point(W_MIN, W_MIN, W_MIN, W_MIN);          // escaped at start, bottom corner
      add_point(Q_TWO, 0, 0, 0);                      // exactly on the radius
      add_point(32'sh1FFF_FFFF, 0, 0, 0);             // just inside the radius
      add_point(0, 0, -Q_TWO, 0);                     // tip of the set, hits radius after one step
      add_point(0, 0, 32'sd67108864, 0);              // cusp at 0.25, slow convergence
      add_point(0, 0, 0, Q_ONE);                      // c = i, periodic orbit
      add_point(0, 0, -32'sd201326592, 32'sd26843546);
      add_point(0, 0, W_MAX, W_MIN);                  // saturated c
      add_point(32'sh1FF0_0000, 0, 32'sh7F00_0000, W_MAX);  // add saturates high
      add_point(0, 32'sh1FF0_0000, W_MIN, W_MIN);     // add saturates low
      add_point(-32'sd402653184, 32'sd322122547, -32'sd107374182, 32'sd161061274);
      add_point(0, 0, 32'sd80530637, 0);              // just outside the cardioid

      // limit of zero: start value comes straight back, never escaped
      set_limit(0);
      add_point(0, 0, 0, 0);
      add_point(W_MAX, 0, 0, 0);

      // limit of one
      set_limit(1);
      add_point(0, 0, 32'sd80530637, 0);
      add_point(Q_TWO, 0, 0, 0);
      add_point(0, 0, -Q_TWO, 0);

      // full 16-bit limit, one point runs the counter to the top
      set_limit(16'hFFFF);
      add_point(0, 0, 32'sd67377300, 0);
      add_point(W_MIN, W_MAX, 0, 0);
      add_point(0, 0, 0, 0);

      // random phases, each with its own limit
      issued = 0;
      phase  = 0;
      while (issued < RANDOM_ITEMS) begin
         sel = $urandom_range(0, 9);
         case (sel)
            0: lim = 0;
            1: lim = 1;
            2: lim = 2;
            3: lim = count_type'($urandom_range(3, 16));
            4, 5: lim = count_type'($urandom_range(17, 100));
            6, 7: lim = MAX_ITER_RESET;
            8: lim = count_type'($urandom_range(4, 40));
            default: lim = ($urandom_range(1)) ? 16'hFFFF : 16'd100;
         endcase
         set_limit(lim);
         // every fifth phase runs back to back with no gaps
         idle_pct = (phase % 5 == 2) ? 0 : 25;
         batch = $urandom_range(15, 50);
         jc_re = word_type'(int'($urandom_range(0, 536870912)) - 268435456);
         jc_im = word_type'(int'($urandom_range(0, 536870912)) - 268435456);
         repeat (batch) begin
            kind = $urandom_range(0, 9);
            if (lim == 16'hFFFF) begin
               // only points that start outside, so the huge limit stays cheap
               sr = word_type'($urandom_range(32'h2000_0000, 32'h7FFF_FFFF));
               if ($urandom_range(1)) sr = -sr;
               if ($urandom_range(1))
                  add_point(sr, word_type'($urandom), word_type'($urandom), word_type'($urandom));
               else
                  add_point(word_type'($urandom), sr, word_type'($urandom), word_type'($urandom));
            end else if (kind < 6) begin
               // mandelbrot: z from origin, c over the interesting window
               add_point(0, 0,
                         word_type'(int'($urandom_range(0, 805306368)) - 603979776),
                         word_type'(int'($urandom_range(0, 805306368)) - 402653184));
            end else if (kind < 8) begin
               // julia: shared c for the phase, z over the square from -2 to 2
               add_point(word_type'(int'($urandom_range(0, 1073741824)) - 536870912),
                         word_type'(int'($urandom_range(0, 1073741824)) - 536870912),
                         jc_re, jc_im);
            end else begin
               // noise over the full word
               add_point(word_type'($urandom), word_type'($urandom),
                         word_type'($urandom), word_type'($urandom));
            end
         end
         issued += batch;
         phase++;
      end

      wait_idle();
      repeat (10) @(posedge clock);
      if (mismatches == 0)
         $display("escape_time_iteration regression: pass");
      else
         $display("escape_time_iteration regression: fail");
      $finish;
   end

endmodule

>>> files.f
hw/rtl/etit_pkg.sv
hw/rtl/etit_ctrl.sv
hw/rtl/etit_dp.sv
hw/rtl/escape_time_iteration.sv
hw/rtl/etit_checker.sv
test/tb_escape_time_iteration.sv
